[rtl/wmdq_pkg.sv]
// ----------------------------------------------------------------------------
// wmdq_pkg
// Shared sizes, constants and state type of the windowed mean and
// deviation quality block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmdq_pkg;

    localparam int WINDOW    = 10;
    localparam int SAMPLE_W  = 20;
    localparam int QUAL_W    = 7;
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int N_W       = $clog2(WINDOW + 1);
    localparam int LOG_W     = $clog2(WINDOW);
    localparam int S_W       = SAMPLE_W + LOG_W;
    localparam int Q_W       = 2 * SAMPLE_W + LOG_W;
    localparam int NQ_W      = N_W + Q_W;
    localparam int D_W       = 2 * S_W;
    localparam int CMP_W     = (NQ_W > D_W) ? NQ_W : D_W;
    localparam int R_W       = S_W;
    localparam int DIV_W     = S_W;
    localparam int SQ_CNT_W  = $clog2(R_W);
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [SAMPLE_W-1:0] LIMIT_RESET = 20'd160000;
    localparam logic [QUAL_W-1:0]   QUAL_MAX    = 7'd100;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [QUAL_W-1:0]   qual_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_MUL_SS,
        ST_MUL_NQ,
        ST_DIFF,
        ST_SQRT,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_SPREAD_GO,
        ST_SPREAD_WAIT,
        ST_OUT
    } wmdq_state_t;

endpackage

`default_nettype wire

[rtl/wmdq_ifs.sv]
// ----------------------------------------------------------------------------
// wmdq interfaces
// Valid/ready channels for samples, results and the limit register.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmdq_in_if import wmdq_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t ppm_sample;

    modport source (output valid, output ppm_sample, input ready);
    modport sink   (input valid, input ppm_sample, output ready);
endinterface

interface wmdq_out_if import wmdq_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t filtered_ppm;
    qual_t   quality;
    logic    sample_valid;

    modport source (output valid, output filtered_ppm, output quality,
                    output sample_valid, input ready);
    modport sink   (input valid, input filtered_ppm, input quality,
                    input sample_valid, output ready);
endinterface

interface wmdq_cfg_if import wmdq_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t valid_limit;

    modport source (output valid, output valid_limit, input ready);
    modport sink   (input valid, input valid_limit, output ready);
endinterface

`default_nettype wire

[rtl/wmdq_div.sv]
// ----------------------------------------------------------------------------
// wmdq_div
// Restoring divider by the fill count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wmdq_div import wmdq_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [N_W-1:0]   divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     work_reg, work_next;
    logic [N_W-1:0]       rem_reg, rem_next;
    logic [N_W-1:0]       dsr_reg, dsr_next;
    logic [N_W:0]         rem_sh;
    logic [N_W:0]         rem_sub;
    logic                 fits;

    assign rem_sh  = {rem_reg, work_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign fits    = (rem_sh >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        priority if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            work_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next  = rem_sub[N_W-1:0];
                work_next = {work_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[N_W-1:0];
                work_next = {work_reg[DIV_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

`default_nettype wire

[rtl/windowed_mean_deviation_quality.sv]
// ----------------------------------------------------------------------------
// windowed_mean_deviation_quality
// Ring-buffer mean of gas samples with a deviation based quality score.
// ----------------------------------------------------------------------------
//  channel     dir  payload                                  handshake
//  sample_in   in   ppm_sample                               valid/ready
//  result_out  out  filtered_ppm, quality, sample_valid      valid/ready
//  cfg         in   valid_limit                              valid/ready
//
//  a sample over the limit goes straight to the output state; a valid one
//  runs through the 24-step square root and two 24-step divisions that
//  share one divider, after one multiply-accumulate step per ring entry
//  sample_in is ready only in idle; one finished item may wait in the
//  output register while the next one is worked on
//  rst_n clears the ring pointers and fill count and sets the limit to 160000
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_mean_deviation_quality import wmdq_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    wmdq_in_if.sink       sample_in,
    wmdq_out_if.source    result_out,
    wmdq_cfg_if.sink      cfg
);

    wmdq_state_t          state_reg, state_next;
    sample_t              limit_reg, limit_next;
    sample_t              ring_reg [WINDOW];
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [N_W-1:0]       fill_reg, fill_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [SQ_CNT_W-1:0]  sq_cnt_reg, sq_cnt_next;
    logic [S_W-1:0]       s_reg, s_next;
    logic [Q_W-1:0]       q_reg, q_next;
    logic [D_W-1:0]       ss_reg, ss_next;
    logic [NQ_W-1:0]      nq_reg, nq_next;
    logic [D_W-1:0]       d_reg, d_next;
    logic [R_W-1:0]       root_reg, root_next;
    logic [R_W:0]         rem_reg, rem_next;
    sample_t              res_ppm_reg, res_ppm_next;
    qual_t                res_qual_reg, res_qual_next;
    logic                 res_sv_reg, res_sv_next;
    logic                 out_valid_reg, out_valid_next;
    sample_t              out_ppm_reg, out_ppm_next;
    qual_t                out_qual_reg, out_qual_next;
    logic                 out_sv_reg, out_sv_next;

    logic                 in_ready;
    logic                 in_fire;
    logic                 x_ok;
    logic                 ring_we;
    logic                 last_entry;
    logic                 out_load;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIV_W-1:0]     div_quot;
    logic [S_W-1:0]       entry;
    logic [S_W-1:0]       mul_a;
    logic [D_W-1:0]       mul_p;
    logic [NQ_W-1:0]      nq_prod;
    logic [CMP_W-1:0]     nq_ext;
    logic [CMP_W-1:0]     ss_ext;
    logic [1:0]           sq_bits;
    logic [R_W+2:0]       sq_rem_sh;
    logic [R_W+2:0]       sq_trial;
    logic [R_W+2:0]       sq_diff;
    logic                 sq_ge;
    logic [R_W+3:0]       ten_root;
    logic [DIV_W-1:0]     spread_num;

    // shared datapath pieces
    assign in_fire    = sample_in.valid & in_ready;
    assign x_ok       = (sample_in.ppm_sample <= limit_reg);
    assign ring_we    = in_fire & x_ok;
    assign last_entry = (idx_reg == SLOT_W'(fill_reg - 1'b1));
    assign entry      = S_W'(ring_reg[idx_reg]);
    assign mul_a      = (state_reg == ST_ACCUM) ? entry : s_reg;
    assign mul_p      = {{S_W{1'b0}}, mul_a} * {{S_W{1'b0}}, mul_a};
    assign nq_prod    = {{Q_W{1'b0}}, fill_reg} * {{N_W{1'b0}}, q_reg};
    assign nq_ext     = CMP_W'(nq_reg);
    assign ss_ext     = CMP_W'(ss_reg);

    // square root digit step
    assign sq_bits    = d_reg[D_W-1 -: 2];
    assign sq_rem_sh  = {rem_reg, sq_bits};
    assign sq_trial   = {1'b0, root_reg, 2'b01};
    assign sq_ge      = (sq_rem_sh >= sq_trial);
    assign sq_diff    = sq_rem_sh - sq_trial;

    // 10 * root / 16
    assign ten_root   = {1'b0, root_reg, 3'b000} + {3'b000, root_reg, 1'b0};
    assign spread_num = ten_root[R_W+3:4];

    wmdq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = x_ok ? ST_ACCUM : ST_OUT;
                end
            end
            ST_ACCUM:
            begin
                if (last_entry)
                begin
                    state_next = ST_MUL_SS;
                end
            end
            ST_MUL_SS:    state_next = ST_MUL_NQ;
            ST_MUL_NQ:    state_next = ST_DIFF;
            ST_DIFF:      state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (sq_cnt_reg == '0)
                begin
                    state_next = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_SPREAD_GO;
                end
            end
            ST_SPREAD_GO: state_next = ST_SPREAD_WAIT;
            ST_SPREAD_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        div_start    = (state_reg == ST_MEAN_GO) || (state_reg == ST_SPREAD_GO);
        div_dividend = (state_reg == ST_SPREAD_GO) ? spread_num : s_reg;
        out_load     = (state_reg == ST_OUT) && (!out_valid_reg || result_out.ready);
    end

    // datapath next values
    always_comb
    begin
        limit_next     = limit_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        sq_cnt_next    = sq_cnt_reg;
        s_next         = s_reg;
        q_next         = q_reg;
        ss_next        = ss_reg;
        nq_next        = nq_reg;
        d_next         = d_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        res_ppm_next   = res_ppm_reg;
        res_qual_next  = res_qual_reg;
        res_sv_next    = res_sv_reg;
        out_ppm_next   = out_ppm_reg;
        out_qual_next  = out_qual_reg;
        out_sv_next    = out_sv_reg;

        if (cfg.valid)
        begin
            limit_next = cfg.valid_limit;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (x_ok)
                    begin
                        s_next   = '0;
                        q_next   = '0;
                        idx_next = '0;
                        slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0
                                                                     : slot_reg + 1'b1;
                        if (fill_reg != N_W'(WINDOW))
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        res_ppm_next  = sample_in.ppm_sample;
                        res_qual_next = '0;
                        res_sv_next   = 1'b0;
                    end
                end
            end
            ST_ACCUM:
            begin
                s_next   = s_reg + entry;
                q_next   = q_reg + Q_W'(mul_p);
                idx_next = idx_reg + 1'b1;
            end
            ST_MUL_SS:
            begin
                ss_next = mul_p;
            end
            ST_MUL_NQ:
            begin
                nq_next = nq_prod;
            end
            ST_DIFF:
            begin
                d_next      = (nq_ext > ss_ext) ? D_W'(nq_ext - ss_ext) : '0;
                root_next   = '0;
                rem_next    = '0;
                sq_cnt_next = SQ_CNT_W'(R_W - 1);
            end
            ST_SQRT:
            begin
                d_next    = {d_reg[D_W-3:0], 2'b00};
                rem_next  = sq_ge ? sq_diff[R_W:0] : sq_rem_sh[R_W:0];
                root_next = {root_reg[R_W-2:0], sq_ge};
                if (sq_cnt_reg != '0)
                begin
                    sq_cnt_next = sq_cnt_reg - 1'b1;
                end
            end
            ST_MEAN_GO:
            begin
            end
            ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    res_ppm_next = div_quot[SAMPLE_W-1:0];
                    res_sv_next  = 1'b1;
                end
            end
            ST_SPREAD_GO:
            begin
            end
            ST_SPREAD_WAIT:
            begin
                if (div_done)
                begin
                    res_qual_next = (div_quot >= DIV_W'(QUAL_MAX)) ? '0
                                    : QUAL_MAX - div_quot[QUAL_W-1:0];
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_ppm_next  = res_ppm_reg;
                    out_qual_next = res_qual_reg;
                    out_sv_next   = res_sv_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            slot_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            sq_cnt_reg    <= sq_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        q_reg        <= q_next;
        ss_reg       <= ss_next;
        nq_reg       <= nq_next;
        d_reg        <= d_next;
        root_reg     <= root_next;
        rem_reg      <= rem_next;
        res_ppm_reg  <= res_ppm_next;
        res_qual_reg <= res_qual_next;
        res_sv_reg   <= res_sv_next;
        out_ppm_reg  <= out_ppm_next;
        out_qual_reg <= out_qual_next;
        out_sv_reg   <= out_sv_next;
    end

    // sample ring
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_reg[slot_reg] <= sample_in.ppm_sample;
        end
    end

    assign sample_in.ready         = in_ready;
    assign cfg.ready               = 1'b1;
    assign result_out.valid        = out_valid_reg;
    assign result_out.filtered_ppm = out_ppm_reg;
    assign result_out.quality      = out_qual_reg;
    assign result_out.sample_valid = out_sv_reg;

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the windowed mean and quality score block against a cycle-free
// predictor: directed cases for the limit edges and the ring, then random
// sample clusters under several limit values and idling patterns, and one
// long output hold-off that stalls the sample input.
// ----------------------------------------------------------------------------

module testbench;
    import wmdq_pkg::*;

    localparam int LATENCY     = WINDOW + 90;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 500;

    typedef struct {
        sample_t    filtered_ppm;
        qual_t      quality;
        logic       sample_valid;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n;

    wmdq_in_if  sample_if ();
    wmdq_out_if result_if ();
    wmdq_cfg_if cfg_if ();

    windowed_mean_deviation_quality u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_if),
        .result_out (result_if),
        .cfg        (cfg_if)
    );

    sample_t  ring_model [WINDOW];
    int       slot_model;
    int       fill_model;
    sample_t  limit_model;
    reading_t pending_readings [$];

    int errors;
    int n_checked;
    int n_rejected;
    int n_q_zero;
    int n_q_full;
    int n_q_mid;
    int sender_idle_pct;
    int stall_pct;
    int hold_request;
    int hold_left;
    int quiet_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = 64'd0;
        for (int k = 31; k >= 0; k--)
        begin
            trial = root | (64'd1 << k);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function reading_t predict_reading(input sample_t x);
        reading_t    r;
        logic [63:0] sum;
        logic [63:0] sum_sq;
        logic [63:0] n;
        logic [63:0] dev;
        logic [63:0] spread;
        if (x > limit_model)
        begin
            r.filtered_ppm = x;
            r.quality      = '0;
            r.sample_valid = 1'b0;
            return r;
        end
        ring_model[slot_model] = x;
        slot_model = (slot_model + 1 >= WINDOW) ? 0 : slot_model + 1;
        if (fill_model < WINDOW)
            fill_model++;
        sum    = 64'd0;
        sum_sq = 64'd0;
        for (int i = 0; i < fill_model; i++)
        begin
            sum    += 64'(ring_model[i]);
            sum_sq += 64'(ring_model[i]) * 64'(ring_model[i]);
        end
        n   = 64'(fill_model);
        dev = n * sum_sq;
        dev = (dev > sum * sum) ? dev - sum * sum : 64'd0;
        spread = (64'd10 * floor_sqrt(dev)) / (64'd16 * n);
        r.filtered_ppm = sample_t'(sum / n);
        r.quality      = (spread >= 64'd100) ? qual_t'(0) : qual_t'(64'd100 - spread);
        r.sample_valid = 1'b1;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        errors++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic send_sample(input sample_t x);
        int gap;
        gap = 0;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct && gap < 40)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_if.valid      <= 1'b1;
        sample_if.ppm_sample <= x;
        do
            @(posedge clk);
        while (sample_if.ready !== 1'b1);
        pending_readings.push_back(predict_reading(x));
    endtask

    task automatic end_stream();
        @(negedge clk);
        sample_if.valid <= 1'b0;
    endtask

    task automatic write_valid_limit(input sample_t v);
        wait (pending_readings.size() == 0);
        repeat (LATENCY) @(posedge clk);
        @(negedge clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.valid_limit <= v;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        limit_model = v;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // starts from a single entry, limit edges at the default limit, quality falling to zero
    task automatic test_single_entry();
        send_sample(20'd0);
        send_sample(LIMIT_RESET);
        send_sample(LIMIT_RESET + 20'd1);
        send_sample(20'hFFFFF);
        send_sample(20'd100);
        send_sample(20'd1600);
        end_stream();
    endtask

    // limit register at both extremes
    task automatic test_limit_extremes();
        write_valid_limit(20'd0);
        send_sample(20'd0);
        send_sample(20'd1);
        send_sample(20'hFFFFF);
        end_stream();
        write_valid_limit(20'hFFFFF);
        send_sample(20'hFFFFF);
        send_sample(20'd0);
        send_sample(20'hAAAAA);
        send_sample(20'h55555);
        send_sample(20'hFFFFF);
        end_stream();
    endtask

    // ring wraps with a tight cluster so quality climbs back
    task automatic test_window_wrap();
        write_valid_limit(LIMIT_RESET);
        for (int i = 0; i < 11; i++)
            send_sample(sample_t'(8000 + 7 * i));
        end_stream();
    endtask

    task automatic run_random_phase(input sample_t lim, input int s_pct, input int r_pct);
        int base;
        int amp;
        int v;
        int pick;
        write_valid_limit(lim);
        sender_idle_pct = s_pct;
        stall_pct       = r_pct;
        base = $urandom_range(int'(lim));
        amp  = 50;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if ($urandom_range(29) == 0)
            begin
                base = $urandom_range(int'(lim));
                case ($urandom_range(2))
                    0:       amp = $urandom_range(8);
                    1:       amp = $urandom_range(60);
                    default: amp = $urandom_range(400);
                endcase
            end
            pick = $urandom_range(99);
            if (pick < 70)
                v = base + int'($urandom_range(2 * amp)) - amp;
            else if (pick < 85)
                v = $urandom_range(20'hFFFFF);
            else
                v = int'(lim) + int'($urandom_range(4)) - 2;
            if (v < 0)
                v = 0;
            if (v > 20'hFFFFF)
                v = 20'hFFFFF;
            send_sample(sample_t'(v));
        end
        end_stream();
        sender_idle_pct = 0;
        stall_pct       = 0;
    endtask

    task automatic test_random_phases();
        run_random_phase(LIMIT_RESET, 0, 0);
        run_random_phase(20'hFFFFF, 63, 0);
        run_random_phase(sample_t'($urandom_range(20'hFFFFF)), 0, 63);
        run_random_phase(sample_t'($urandom_range(20'hFFFFF, 20'h80000)), 18, 18);
    endtask

    // output held off long enough that the input stalls
    task automatic test_backpressure();
        write_valid_limit(LIMIT_RESET);
        hold_request = 600;
        for (int i = 0; i < 15; i++)
            send_sample(sample_t'($urandom_range(40000, 40300)));
        end_stream();
    endtask

    task automatic finish_run();
        wait (pending_readings.size() == 0);
        repeat (LATENCY) @(posedge clk);
        if (pending_readings.size() != 0)
            flag_mismatch("items still expected at end of run");
        $display("checked %0d items: %0d over the limit, quality 100 in %0d, zero in %0d",
                 n_checked, n_rejected, n_q_full, n_q_zero);
        $display("intermediate quality in %0d, limit set to 0, max and random values",
                 n_q_mid);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    endtask

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (pending_readings.size() == 0)
                flag_mismatch("result with no item pending");
            else
            begin
                want = pending_readings.pop_front();
                n_checked++;
                if (!want.sample_valid)
                    n_rejected++;
                else if (want.quality == QUAL_MAX)
                    n_q_full++;
                else if (want.quality == 0)
                    n_q_zero++;
                else
                    n_q_mid++;
                if (result_if.filtered_ppm !== want.filtered_ppm)
                    flag_mismatch($sformatf("filtered_ppm %0d, want %0d",
                                            result_if.filtered_ppm, want.filtered_ppm));
                if (result_if.quality !== want.quality)
                    flag_mismatch($sformatf("quality %0d, want %0d",
                                            result_if.quality, want.quality));
                if (result_if.sample_valid !== want.sample_valid)
                    flag_mismatch($sformatf("sample_valid %0b, want %0b",
                                            result_if.sample_valid, want.sample_valid));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_if.valid === 1'b1 && sample_if.ready === 1'b1) ||
            (result_if.valid === 1'b1 && result_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        sample_if.valid      = 1'b0;
        sample_if.ppm_sample = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.valid_limit   = '0;
        result_if.ready      = 1'b0;
        sender_idle_pct      = 0;
        stall_pct            = 0;
        hold_request         = 0;
        hold_left            = 0;
        quiet_cycles         = 0;
        errors               = 0;
        n_checked            = 0;
        n_rejected           = 0;
        n_q_zero             = 0;
        n_q_full             = 0;
        n_q_mid              = 0;
        slot_model           = 0;
        fill_model           = 0;
        limit_model          = LIMIT_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_single_entry();
        test_limit_extremes();
        test_window_wrap();
        test_random_phases();
        test_backpressure();
        finish_run();
    end

endmodule
